>>> hw/rtl/lmsaf_pkg.sv
// Shared types, constants and saturation helpers for the LMS adaptive FIR.
// No dependencies; used by lmsaf_cell, lms_adaptive_fir_unit and the testbench.
`timescale 1ns / 1ps

package lmsaf_pkg;

  // Sample and weight formats
  localparam int SMP_W = 16;  // Q1.15
  localparam int WGT_W = 32;  // Q2.30
  localparam int MU_W  = 16;  // Q0.16 unsigned
  localparam int PRD_W = WGT_W + SMP_W;  // shared multiplier product

  // Defaults and reset values
  localparam int MAX_TAPS_DEF = 32;
  localparam int TAPS_RESET   = 32;
  localparam logic [MU_W-1:0] STEP_RESET = 16'd328;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE = 1'b1;
  localparam int CFG_DATA_W = 16;

  // One tap: weight and the sample that lines up with it
  typedef struct packed {
    logic signed [WGT_W-1:0] w;
    logic signed [SMP_W-1:0] s;
  } tap_t;

  // Control shared by every cell in the ring
  typedef struct packed {
    logic clear;   // zero weight and sample
    logic shift;   // take a new sample from the left neighbor
    logic rotate;  // take the whole tap from the right neighbor
  } cell_ctrl_t;

  // Clip a 17-bit signed value to 16 bits
  function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [SMP_W:0] v);
    logic signed [SMP_W-1:0] r;
    if (v[SMP_W] != v[SMP_W-1]) begin
      r = v[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

  // Clip a 33-bit signed value to 32 bits
  function automatic logic signed [WGT_W-1:0] sat_wgt(input logic signed [WGT_W:0] v);
    logic signed [WGT_W-1:0] r;
    if (v[WGT_W] != v[WGT_W-1]) begin
      r = v[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}};
    end else begin
      r = v[WGT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/lmsaf_cell.sv
// One tap cell of the LMS ring: holds a weight and its delay-line sample.
// Depends on lmsaf_pkg for tap_t and cell_ctrl_t.
`timescale 1ns / 1ps

module lmsaf_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lmsaf_pkg::cell_ctrl_t                  ctrl,
  input  logic signed [lmsaf_pkg::SMP_W-1:0]     smp_in,
  input  lmsaf_pkg::tap_t                        rot_in,
  output lmsaf_pkg::tap_t                        tap
);

  // Clear, shift the delay line, or rotate the ring
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      tap <= '0;
    end else if (ctrl.shift) begin
      tap.s <= smp_in;
    end else if (ctrl.rotate) begin
      tap <= rot_in;
    end
  end

endmodule

>>> hw/rtl/lms_adaptive_fir_unit.sv
// LMS adaptive FIR filter top level: tap cell ring, shared multiplier, control.
// Depends on lmsaf_pkg and lmsaf_cell.
`timescale 1ns / 1ps

// The block takes one transaction of {desired, sample_in} and returns one of
// {error_out, filter_out} with the saturation flag in m_tuser. Each item is
// processed in full before the next is accepted: the tap cells form a ring
// that rotates past a single 32x16 multiplier twice, once to accumulate the
// output and once to update the weights, and each pass steps through all
// MAX_TAPS cells whatever taps_in_use is.
// The delay line is a shift register in the cells, so taps beyond
// taps_in_use are carried but ignored. A finished result waits in the output
// register while the next input is taken. Writing taps_in_use clears all
// weights and samples at once; step_size may be rewritten at any idle time.

module lms_adaptive_fir_unit #(
  parameter int MAX_TAPS = lmsaf_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata: sample_in [15:0], desired [31:16]
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [31:0]                          s_tdata,
  // m_tdata: filter_out [15:0], error_out [31:16]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [31:0]                          m_tdata,
  // m_tuser: saturated [0]
  output logic                                 m_tuser,
  input  logic                                 cfg_we,
  input  logic [lmsaf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmsaf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW  = lmsaf_pkg::SMP_W;
  localparam int WW  = lmsaf_pkg::WGT_W;
  localparam int PW  = lmsaf_pkg::PRD_W;
  localparam int IW  = $clog2(MAX_TAPS);
  localparam int LW  = $clog2(MAX_TAPS + 1);
  localparam int AW  = PW + $clog2(MAX_TAPS);
  localparam int LEN_RESET =
    (lmsaf_pkg::TAPS_RESET > MAX_TAPS) ? MAX_TAPS : lmsaf_pkg::TAPS_RESET;
  localparam logic [IW-1:0] J_LAST = IW'(MAX_TAPS - 1);
  localparam logic signed [AW-1:0] ACC_HALF = AW'(64'sd1 <<< 29);
  localparam logic signed [AW-1:0] Y_MAX = AW'(32767);
  localparam logic signed [AW-1:0] Y_MIN = AW'(-32768);
  localparam logic signed [PW-1:0] PRD_HALF = PW'(64'sd1 <<< 15);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_MAC_END, ST_Y, ST_E, ST_MUE, ST_PRIME, ST_UPD, ST_DONE
  } state_t;

  state_t state;
  logic [IW-1:0] j;
  logic          prod_v;

  // Configuration registers
  logic [lmsaf_pkg::MU_W-1:0] step_size;
  logic [LW-1:0]              len;
  logic [5:0]                 len_wr;

  // Datapath registers
  logic signed [SW-1:0] desired;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic signed [SW-1:0] y;
  logic signed [SW-1:0] e;
  logic signed [WW-1:0] mue;
  logic                 sat;

  // Cell ring
  lmsaf_pkg::tap_t       taps [MAX_TAPS];
  lmsaf_pkg::tap_t       head_wb;
  lmsaf_pkg::cell_ctrl_t cctrl;

  logic                 accept;
  logic                 tap_act;
  logic signed [WW-1:0] mul_a;
  logic signed [SW-1:0] mul_b;
  logic signed [AW-1:0] prod_ext;
  logic signed [AW-1:0] acc_rnd;
  logic signed [AW-1:0] y_wide;
  logic                 y_ovf;
  logic signed [SW-1:0] y_clip;
  logic signed [SW:0]   e_diff;
  logic signed [WW+SW:0] mue_full;
  logic signed [PW-1:0] prod_rnd;
  logic signed [WW:0]   w_sum;
  logic                 w_ovf;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign tap_act  = (LW'(j) < len);

  // Ring control
  always_comb begin
    cctrl.clear  = cfg_we && (cfg_index == lmsaf_pkg::REG_TAPS_IN_USE);
    cctrl.shift  = accept;
    cctrl.rotate = (state == ST_MAC) || (state == ST_UPD);
  end

  // Build the ring: samples shift right, taps rotate left toward cell 0
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic signed [SW-1:0] smp_in;
    lmsaf_pkg::tap_t      rot_in;
    if (k == 0) begin : g_first
      assign smp_in = s_tdata[15:0];
    end else begin : g_mid
      assign smp_in = taps[k-1].s;
    end
    if (k == MAX_TAPS - 1) begin : g_last
      assign rot_in = head_wb;
    end else begin : g_inner
      assign rot_in = taps[k+1];
    end
    lmsaf_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (cctrl),
      .smp_in (smp_in),
      .rot_in (rot_in),
      .tap    (taps[k])
    );
  end

  // Shared multiplier operands: weight pass uses cell 0, update looks one ahead
  assign mul_a = (state == ST_MAC) ? taps[0].w : mue;
  assign mul_b = (state == ST_UPD) ? taps[1].s : taps[0].s;

  // Output rounding and clipping, error difference and step-scaled error
  always_comb begin
    prod_ext = AW'(prod);
    acc_rnd  = acc + ACC_HALF;
    y_wide   = acc_rnd >>> 30;
    y_ovf    = (y_wide > Y_MAX) || (y_wide < Y_MIN);
    if (y_wide > Y_MAX) begin
      y_clip = {1'b0, {(SW-1){1'b1}}};
    end else if (y_wide < Y_MIN) begin
      y_clip = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_clip = y_wide[SW-1:0];
    end
    e_diff   = {desired[SW-1], desired} - {y[SW-1], y};
    mue_full = $signed({1'b0, step_size}) * e;
  end

  // Weight update at the head cell
  always_comb begin
    prod_rnd  = (prod + PRD_HALF) >>> 16;
    w_sum     = {taps[0].w[WW-1], taps[0].w} + {prod_rnd[WW-1], prod_rnd[WW-1:0]};
    w_ovf     = (w_sum[WW] != w_sum[WW-1]);
    head_wb.s = taps[0].s;
    if ((state == ST_UPD) && tap_act) begin
      head_wb.w = lmsaf_pkg::sat_wgt(w_sum);
    end else begin
      head_wb.w = taps[0].w;
    end
  end

  // Configuration writes
  assign len_wr = cfg_data[5:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= lmsaf_pkg::STEP_RESET;
      len       <= LW'(LEN_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmsaf_pkg::REG_STEP_SIZE:   step_size <= cfg_data;
        lmsaf_pkg::REG_TAPS_IN_USE: begin
          if (len_wr == 6'd0) begin
            len <= LW'(1);
          end else if (int'(len_wr) > MAX_TAPS) begin
            len <= LW'(MAX_TAPS);
          end else begin
            len <= LW'(len_wr);
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer: state, tap counter and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      j        <= '0;
      prod_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Load a new result or drop the one just taken
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      prod_v <= (state == ST_MAC) && tap_act;
      unique case (state)
        ST_IDLE: begin
          j <= '0;
          if (accept) begin
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          j <= j + 1'b1;
          if (j == J_LAST) begin
            state <= ST_MAC_END;
          end
        end
        ST_MAC_END: state <= ST_Y;
        ST_Y:       state <= ST_E;
        ST_E:       state <= ST_MUE;
        ST_MUE:     state <= ST_PRIME;
        ST_PRIME: begin
          j     <= '0;
          state <= ST_UPD;
        end
        ST_UPD: begin
          j <= j + 1'b1;
          if (j == J_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      desired <= s_tdata[31:16];
      acc     <= '0;
      sat     <= 1'b0;
    end
    if ((state == ST_MAC) || (state == ST_MAC_END)) begin
      if (prod_v) begin
        acc <= acc + prod_ext;
      end
    end
    if (state == ST_Y) begin
      y <= y_clip;
      if (y_ovf) begin
        sat <= 1'b1;
      end
    end
    if (state == ST_E) begin
      e <= lmsaf_pkg::sat_smp(e_diff);
      if (e_diff[SW] != e_diff[SW-1]) begin
        sat <= 1'b1;
      end
    end
    if (state == ST_MUE) begin
      mue <= mue_full[WW-1:0];
    end
    if ((state == ST_UPD) && tap_act && w_ovf) begin
      sat <= 1'b1;
    end
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {e, y};
      m_tuser <= sat;
    end
  end

endmodule

>>> hw/rtl/lmsaf_checker.sv
// Port-level checks for lms_adaptive_fir_unit, attached by bind.
// Depends on the top level's port names only.
`timescale 1ns / 1ps

module lmsaf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Drop ready once an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // A new result appears only at the end of processing
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without a transaction in flight");

  // No result in the cycle right after acceptance
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result too early");

  // Come out of reset with no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind lms_adaptive_fir_unit lmsaf_checker u_lmsaf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> verif/lms_adaptive_fir_unit_test.sv
// Self-checking testbench for lms_adaptive_fir_unit: directed table, then random streams.
// Results are checked against a fixed-point LMS predictor kept in this file.
// Depends on lmsaf_pkg and the unit's RTL.
`timescale 1ns / 1ps

module lms_adaptive_fir_unit_test;

  localparam int SMP_W = lmsaf_pkg::SMP_W;
  localparam int WGT_W = lmsaf_pkg::WGT_W;
  localparam int MU_W = lmsaf_pkg::MU_W;
  localparam int CFG_IDX_W = lmsaf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = lmsaf_pkg::CFG_DATA_W;
  localparam int TAPS = lmsaf_pkg::MAX_TAPS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 2 * TAPS + 16;
  localparam int SEG_ITEMS = 150;
  localparam int SEGS_PER_PHASE = 4;

  localparam logic signed [SMP_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SMP_W-1:0] S_MAX = 16'sh7FFF;
  localparam longint Y_LO = -32768;
  localparam longint Y_HI = 32767;
  localparam longint W_LO = -(longint'(1) <<< 31);
  localparam longint W_HI = (longint'(1) <<< 31) - 1;

  typedef struct packed {
    logic signed [SMP_W-1:0] y;
    logic signed [SMP_W-1:0] e;
    logic                    sat;
  } fir_out_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;
  typedef enum int {MODE_TRACK, MODE_NOISE, MODE_EDGE} pair_mode_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic signed [SMP_W-1:0] x;
    logic signed [SMP_W-1:0] d;
    bit                      typed;
    fir_out_t                want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lms_adaptive_fir_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state: circular delay line, weights, position and registers
  logic signed [SMP_W-1:0] sample_line [TAPS];
  logic signed [WGT_W-1:0] tap_weight [TAPS];
  int unsigned             tap_pos;
  int unsigned             tap_count;
  logic [MU_W-1:0]         mu_step;

  fir_out_t pending_outputs [$];
  fir_out_t head_out;
  dir_row_t plan [$];
  logic signed [SMP_W-1:0] x_hist [3];

  int mismatches = 0;
  int stall_cycles = 0;
  int send_idle_pct = 23;
  int recv_idle_pct = 73;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_len(int unsigned v);
    if (v < 1) return 1;
    if (v > TAPS) return TAPS;
    return v;
  endfunction

  function automatic void clear_model();
    for (int k = 0; k < TAPS; k++) begin
      sample_line[k] = '0;
      tap_weight[k] = '0;
    end
    tap_pos = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == lmsaf_pkg::REG_STEP_SIZE) begin
      mu_step = data[MU_W-1:0];
    end else if (idx == lmsaf_pkg::REG_TAPS_IN_USE) begin
      tap_count = clamp_len(data[5:0]);
      clear_model();
    end
  endfunction

  // Round to nearest by adding half an LSB, then floor shift
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_to(longint v, longint lo, longint hi, inout bit hit);
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    return v;
  endfunction

  // One LMS step: insert sample, filter, form error, update every active weight
  function automatic fir_out_t lms_step(logic signed [SMP_W-1:0] x, logic signed [SMP_W-1:0] d);
    fir_out_t    r;
    int unsigned pos;
    int unsigned idx;
    longint      acc;
    longint      y;
    longint      e;
    longint      p;
    longint      w;
    longint      mu_l;
    bit          hit;
    hit = 1'b0;
    mu_l = mu_step;
    pos = tap_pos % tap_count;
    sample_line[pos] = x;
    acc = 0;
    for (int unsigned k = 0; k < tap_count; k++) begin
      idx = (pos + tap_count - k) % tap_count;
      acc += longint'(tap_weight[k]) * longint'(sample_line[idx]);
    end
    y = clip_to(round_shift(acc, 30), Y_LO, Y_HI, hit);
    e = clip_to(longint'(d) - y, Y_LO, Y_HI, hit);
    for (int unsigned k = 0; k < tap_count; k++) begin
      idx = (pos + tap_count - k) % tap_count;
      p = mu_l * e * longint'(sample_line[idx]);
      w = longint'(tap_weight[k]) + round_shift(p, 16);
      tap_weight[k] = WGT_W'(clip_to(w, W_LO, W_HI, hit));
    end
    tap_pos = (pos + 1) % tap_count;
    r.y = y[SMP_W-1:0];
    r.e = e[SMP_W-1:0];
    r.sat = hit;
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] clip16(int v);
    if (v < Y_LO) return S_MIN;
    if (v > Y_HI) return S_MAX;
    return v[SMP_W-1:0];
  endfunction

  // Random pair: mostly a plant to track, some noise, some edge values
  function automatic logic [31:0] next_pair();
    logic signed [SMP_W-1:0] x;
    logic signed [SMP_W-1:0] d;
    logic signed [SMP_W-1:0] edge_vals [5];
    int                      sel;
    int                      noise;
    pair_mode_t              mode;
    edge_vals = '{S_MIN, S_MAX, 16'sd0, -16'sd1, 16'sd1};
    sel = $urandom_range(99);
    mode = (sel < 65) ? MODE_TRACK : (sel < 85) ? MODE_NOISE : MODE_EDGE;
    x = SMP_W'($urandom());
    d = SMP_W'($urandom());
    case (mode)
      MODE_TRACK: begin
        x = x >>> $urandom_range(3);
        noise = int'($urandom_range(64)) - 32;
        d = clip16(int'(x_hist[0]) / 2 - int'(x_hist[2]) / 4 + int'(x) / 8 + noise);
      end
      MODE_EDGE: begin
        x = edge_vals[$urandom_range(4)];
        d = edge_vals[$urandom_range(4)];
      end
      default: begin
      end
    endcase
    x_hist[2] = x_hist[1];
    x_hist[1] = x_hist[0];
    x_hist[0] = x;
    return {d, x};
  endfunction

  function automatic dir_row_t wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r = '{ROW_WRITE, idx, data, 16'sd0, 16'sd0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t smp(logic signed [SMP_W-1:0] x, logic signed [SMP_W-1:0] d);
    dir_row_t r;
    r = '{ROW_SAMPLE, lmsaf_pkg::REG_STEP_SIZE, '0, x, d, 1'b0, '0};
    return r;
  endfunction

  // Sample whose result is known outright: weights were just cleared, so y = 0, e = d
  function automatic dir_row_t smp_clear(logic signed [SMP_W-1:0] x, logic signed [SMP_W-1:0] d);
    dir_row_t r;
    r = '{ROW_SAMPLE, lmsaf_pkg::REG_STEP_SIZE, '0, x, d, 1'b1, '{16'sd0, d, 1'b0}};
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one transaction, hold it until accepted, then log its prediction
  task automatic feed_pair(input logic signed [SMP_W-1:0] x, input logic signed [SMP_W-1:0] d,
                           input bit typed, input fir_out_t want);
    fir_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {d, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = lms_step(x, d);
    pending_outputs.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // Hold off the sender until every result is back, then let the block settle
  task automatic flush_outputs();
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    flush_outputs();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Randomize the receiver's readiness every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each output transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outputs.size() == 0) begin
        note_mismatch($sformatf("unexpected output data=%h flag=%b", m_tdata, m_tuser));
      end else begin
        head_out = pending_outputs.pop_front();
        if (m_tdata[15:0] !== head_out.y)
          note_mismatch($sformatf("filter_out got %0d want %0d",
                                  $signed(m_tdata[15:0]), head_out.y));
        if (m_tdata[31:16] !== head_out.e)
          note_mismatch($sformatf("error_out got %0d want %0d",
                                  $signed(m_tdata[31:16]), head_out.e));
        if (m_tuser !== head_out.sat)
          note_mismatch($sformatf("saturated got %b want %b", m_tuser, head_out.sat));
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_outputs.size());
      $display("** lms_adaptive_fir_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [31:0]           pair;
    logic [CFG_DATA_W-1:0] val;
    rst = 1'b1;
    x_hist = '{16'sd0, 16'sd0, 16'sd0};
    mu_step = lmsaf_pkg::STEP_RESET;
    tap_count = clamp_len(lmsaf_pkg::TAPS_RESET);
    clear_model();

    plan = '{
      // fresh from reset, default step and full length
      smp_clear(S_MAX, S_MIN),
      smp(S_MIN, S_MAX),
      smp(16'sd0, 16'sd0),
      smp(-16'sd1, 16'sd1),
      smp(16'sh5555, 16'shAAAA),
      // largest step on a single tap drives the output and weights into clipping
      wr(lmsaf_pkg::REG_STEP_SIZE, 16'hFFFF),
      wr(lmsaf_pkg::REG_TAPS_IN_USE, 16'd1),
      smp_clear(S_MIN, S_MAX),
      smp(S_MIN, S_MAX),
      smp(S_MAX, S_MIN),
      smp(S_MIN, S_MIN),
      smp(S_MIN, S_MAX),
      smp(S_MAX, S_MAX),
      // zero length acts as one tap
      wr(lmsaf_pkg::REG_TAPS_IN_USE, 16'd0),
      smp_clear(16'sd12345, S_MIN),
      smp(S_MAX, S_MAX),
      // oversized length clamps to the full ring
      wr(lmsaf_pkg::REG_TAPS_IN_USE, 16'd63),
      smp_clear(S_MIN, S_MIN),
      smp(S_MAX, S_MIN),
      smp(S_MIN, S_MAX),
      smp(16'sh00FF, 16'shFF00),
      // zero step freezes the weights, state is kept
      wr(lmsaf_pkg::REG_STEP_SIZE, 16'h0000),
      smp(16'sd1000, -16'sd1000),
      smp(-16'sd1000, 16'sd1000),
      // upper data bits fall outside the length field: five taps
      wr(lmsaf_pkg::REG_TAPS_IN_USE, 16'hFFC5),
      smp_clear(16'sh7F00, 16'sh0123),
      wr(lmsaf_pkg::REG_STEP_SIZE, lmsaf_pkg::STEP_RESET),
      smp(16'sh0A0A, 16'sh5050),
      smp(-16'sh0A0A, -16'sh5050)
    };

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        load_reg(plan[i].idx, plan[i].data);
      end else begin
        feed_pair(plan[i].x, plan[i].d, plan[i].typed, plan[i].want);
      end
    end

    // Random streams: three idle profiles, new settings before every segment
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGS_PER_PHASE; seg++) begin
        case ($urandom_range(5))
          0: val = 16'hFFFF;
          1: val = 16'h0000;
          2: val = CFG_DATA_W'($urandom_range(1, 2000));
          3: val = CFG_DATA_W'($urandom());
          default: val = lmsaf_pkg::STEP_RESET;
        endcase
        load_reg(lmsaf_pkg::REG_STEP_SIZE, val);
        // now and then keep the adapted state across a step change
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(6))
            0: val = 16'd1;
            1: val = 16'd2;
            2: val = 16'd32;
            3: val = 16'd0;
            4: val = 16'd63;
            5: val = CFG_DATA_W'($urandom());
            default: val = CFG_DATA_W'($urandom_range(1, TAPS));
          endcase
          load_reg(lmsaf_pkg::REG_TAPS_IN_USE, val);
        end
        for (int n = 0; n < SEG_ITEMS; n++) begin
          pair = next_pair();
          feed_pair(pair[15:0], pair[31:16], 1'b0, '0);
        end
      end
    end

    flush_outputs();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** lms_adaptive_fir_unit: PASSED **");
    end else begin
      $display("** lms_adaptive_fir_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/lmsaf_pkg.sv
hw/rtl/lmsaf_cell.sv
hw/rtl/lms_adaptive_fir_unit.sv
hw/rtl/lmsaf_checker.sv
verif/lms_adaptive_fir_unit_test.sv
